@@ hdl/brf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared constants, codes and types of the circular byte fifo block.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int LANES_DEF    = 8;

    // field widths of the stream payloads
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 4;
    localparam int DATA_W   = 64;
    localparam int LEVEL_W  = 11;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TRIM  = 2'd3;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } brf_state_t;

endpackage

@@ hdl/byte_ring_fifo_block_access_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_block_access_unit
// Circular byte fifo with all-or-nothing block write and read, clear and trim.
// ----------------------------------------------------------------------------
//  channel   side    payload
//  s_axis    in      tuser: action | tdata: byte_count, write_data, keep_bytes
//  m_axis    out     tuser: status | tdata: done_count, read_data, fill_level,
//                                           free_space
//
//  write, clear and trim with nothing to drop: result registered in the cycle after transfer
//  read: registered bank read, then packing into the registered result
//  trim that drops bytes: reciprocal divide of the drop by the lane count
//    registers dividend, then quotient and remainder, before pointers and result
//  one item at a time; input is held off while a result waits untaken
//  reset clears the pointers and fill count; the store needs no clearing pass
// ----------------------------------------------------------------------------
module byte_ring_fifo_block_access_unit
    import brf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LANES    = LANES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_count[3:0], write_data[67:4], keep_bytes[78:68], zero[79]
    input  logic [79:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // done_count[3:0], read_data[67:4], fill_level[78:68], free_space[89:79],
    // zero[95:90]
    output logic [95:0] m_axis_tdata,
    // status[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int ROWS = (CAPACITY + LANES - 1) / LANES;
    localparam int BW   = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int TW   = $clog2(2 * LANES);
    localparam int CMPW = (CW > LEVEL_W) ? CW : LEVEL_W;
    localparam int SW   = ((RW > CW) ? RW : CW) + 1;

    brf_state_t state_reg, state_next;

    logic [CW-1:0]      fill_reg, fill_next;
    logic [BW-1:0]      wb_reg, wb_next, rb_reg, rb_next;
    logic [RW-1:0]      wr_reg, wr_next, rr_reg, rr_next;
    logic               out_valid_reg, out_valid_next;
    logic               status_reg, status_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic [DATA_W-1:0]  rdata_reg, rdata_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] free_reg, free_next;

    logic [ACTION_W-1:0] in_action;
    logic [COUNT_W-1:0]  in_count;
    logic [DATA_W-1:0]   in_wdata;
    logic [LEVEL_W-1:0]  in_keep;
    logic [COUNT_W-1:0]  cnt;
    logic                s_acc;
    logic [CW-1:0]       free_now;
    logic [TW-1:0]       bank_sum;
    logic [TW-1:0]       trim_bank_sum;
    logic [SW-1:0]       trim_row_sum;

    logic               lane_wr_en, lane_rd_en;
    logic [BW-1:0]      lane_base_bank;
    logic [RW-1:0]      lane_base_row;
    logic [LANES-1:0][7:0]    lane_byte;
    logic [LANES-1:0][BW-1:0] lane_off;
    logic [LANES-1:0]         lane_act;
    logic [DATA_W-1:0]  merge_data;

    logic               div_start, div_done;
    logic [CW-1:0]      div_dividend, div_quot;
    logic [TW-1:0]      div_rem;

    assign in_count  = s_axis_tdata[3:0];
    assign in_wdata  = s_axis_tdata[67:4];
    assign in_keep   = s_axis_tdata[78:68];
    assign in_action = s_axis_tuser;

    assign cnt = (in_count > COUNT_W'(LANES)) ? COUNT_W'(LANES) : in_count;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign free_now      = CW'(CAPACITY) - fill_reg;

    assign lane_base_bank = (in_action == ACT_WRITE) ? wb_reg : rb_reg;
    assign lane_base_row  = (in_action == ACT_WRITE) ? wr_reg : rr_reg;

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            brf_lane #(
                .LANES (LANES),
                .ROWS  (ROWS)
            ) u_lane (
                .clk       (clk),
                .bank_id   (BW'(g)),
                .base_bank (lane_base_bank),
                .base_row  (lane_base_row),
                .count     (cnt),
                .wr_en     (lane_wr_en),
                .rd_en     (lane_rd_en),
                .wdata     (in_wdata),
                .rd_byte   (lane_byte[g]),
                .rd_off    (lane_off[g]),
                .rd_act    (lane_act[g])
            );
        end
    endgenerate

    brf_merge #(
        .LANES (LANES)
    ) u_merge (
        .lane_byte (lane_byte),
        .lane_off  (lane_off),
        .lane_act  (lane_act),
        .read_data (merge_data)
    );

    brf_div #(
        .DW    (CW),
        .LANES (LANES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            wb_reg        <= '0;
            wr_reg        <= '0;
            rb_reg        <= '0;
            rr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wb_reg        <= wb_next;
            wr_reg        <= wr_next;
            rb_reg        <= rb_next;
            rr_reg        <= rr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        done_reg   <= done_next;
        rdata_reg  <= rdata_next;
        level_reg  <= level_next;
        free_reg   <= free_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        wb_next        = wb_reg;
        wr_next        = wr_reg;
        rb_next        = rb_reg;
        rr_next        = rr_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        done_next      = done_reg;
        rdata_next     = rdata_reg;
        level_next     = level_reg;
        free_next      = free_reg;
        lane_wr_en     = 1'b0;
        lane_rd_en     = 1'b0;
        div_start      = 1'b0;
        div_dividend   = fill_reg - CW'(in_keep);
        bank_sum       = TW'(lane_base_bank) + TW'(cnt);
        trim_bank_sum  = TW'(rb_reg) + div_rem;
        trim_row_sum   = SW'(rr_reg) + SW'(div_quot);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    status_next    = STATUS_DONE;
                    done_next      = '0;
                    rdata_next     = '0;
                    out_valid_next = 1'b1;
                    case (in_action)
                        ACT_WRITE:
                        begin
                            if (CMPW'(cnt) > CMPW'(free_now))
                            begin
                                status_next = STATUS_REFUSED;
                            end
                            else
                            begin
                                lane_wr_en = 1'b1;
                                done_next  = cnt;
                                fill_next  = fill_reg + CW'(cnt);
                                if (bank_sum >= TW'(LANES))
                                begin
                                    wb_next = BW'(bank_sum - TW'(LANES));
                                    wr_next = (wr_reg == RW'(ROWS - 1)) ? '0
                                                                       : wr_reg + RW'(1);
                                end
                                else
                                begin
                                    wb_next = BW'(bank_sum);
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            if (CMPW'(cnt) > CMPW'(fill_reg))
                            begin
                                status_next = STATUS_REFUSED;
                            end
                            else
                            begin
                                lane_rd_en     = 1'b1;
                                done_next      = cnt;
                                fill_next      = fill_reg - CW'(cnt);
                                out_valid_next = 1'b0;
                                state_next     = ST_READ;
                                if (bank_sum >= TW'(LANES))
                                begin
                                    rb_next = BW'(bank_sum - TW'(LANES));
                                    rr_next = (rr_reg == RW'(ROWS - 1)) ? '0
                                                                       : rr_reg + RW'(1);
                                end
                                else
                                begin
                                    rb_next = BW'(bank_sum);
                                end
                            end
                        end
                        ACT_CLEAR:
                        begin
                            fill_next = '0;
                            wb_next   = '0;
                            wr_next   = '0;
                            rb_next   = '0;
                            rr_next   = '0;
                        end
                        default:
                        begin
                            // trim: read pointer moves on once the drop is split
                            if (CMPW'(fill_reg) > CMPW'(in_keep))
                            begin
                                fill_next      = CW'(in_keep);
                                div_start      = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = ST_DIV;
                            end
                        end
                    endcase
                    level_next = LEVEL_W'(fill_next);
                    free_next  = LEVEL_W'(CW'(CAPACITY) - fill_next);
                end
            end
            ST_READ:
            begin
                rdata_next     = merge_data;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (trim_bank_sum >= TW'(LANES))
                    begin
                        rb_next      = BW'(trim_bank_sum - TW'(LANES));
                        trim_row_sum = trim_row_sum + SW'(1);
                    end
                    else
                    begin
                        rb_next = BW'(trim_bank_sum);
                    end
                    if (trim_row_sum >= SW'(ROWS))
                    begin
                        rr_next = RW'(trim_row_sum - SW'(ROWS));
                    end
                    else
                    begin
                        rr_next = RW'(trim_row_sum);
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {6'b000000, free_reg, level_reg, rdata_reg, done_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_read_to_merge: assert property (@(posedge clk) disable iff (!rst_n)
        lane_rd_en |=> (state_reg == ST_READ) && !out_valid_reg)
        else $error("bank read not followed by packing cycle");

    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_acc)
        else $error("item taken while result still waits");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divide finished outside trim wait");

endmodule

@@ hdl/brf_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_lane
// One byte bank of the store with its own address and byte-select logic.
// ----------------------------------------------------------------------------
module brf_lane
    import brf_pkg::*;
#(
    parameter int LANES = LANES_DEF,
    parameter int ROWS  = (CAPACITY_DEF + LANES_DEF - 1) / LANES_DEF
)
(
    input  logic                                   clk,
    input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] bank_id,
    input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] base_bank,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0]   base_row,
    input  logic [COUNT_W-1:0]                     count,
    input  logic                                   wr_en,
    input  logic                                   rd_en,
    input  logic [DATA_W-1:0]                      wdata,
    output logic [7:0]                             rd_byte,
    output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] rd_off,
    output logic                                   rd_act
);

    localparam int BW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW = $clog2(2 * LANES);

    logic [7:0]    mem [ROWS];
    logic [TW-1:0] off_sum;
    logic [BW-1:0] off;
    logic          active;
    logic [RW-1:0] row_inc;
    logic [RW-1:0] row;

    // position of this bank within the block, counted from the base bank
    always_comb
    begin
        if (bank_id >= base_bank)
        begin
            off_sum = TW'(bank_id) - TW'(base_bank);
        end
        else
        begin
            off_sum = TW'(bank_id) + TW'(LANES) - TW'(base_bank);
        end
        off     = off_sum[BW-1:0];
        active  = COUNT_W'(off_sum) < count;
        row_inc = (base_row == RW'(ROWS - 1)) ? '0 : base_row + RW'(1);
        // banks below the base bank hold bytes of the following row
        row     = (bank_id < base_bank) ? row_inc : base_row;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && active)
        begin
            mem[row] <= wdata[{off, 3'b000} +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_byte <= mem[row];
            rd_off  <= off;
            rd_act  <= active;
        end
    end

endmodule

@@ hdl/brf_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_merge
// Packs the bytes read by the banks into one word, oldest byte lowest.
// ----------------------------------------------------------------------------
module brf_merge
    import brf_pkg::*;
#(
    parameter int LANES = LANES_DEF
)
(
    input  logic [LANES-1:0][7:0]                            lane_byte,
    input  logic [LANES-1:0][((LANES > 1) ? $clog2(LANES) : 1)-1:0] lane_off,
    input  logic [LANES-1:0]                                 lane_act,
    output logic [DATA_W-1:0]                                read_data
);

    // each active bank drops its byte into its slot, unused slots stay zero
    always_comb
    begin
        read_data = '0;
        for (int b = 0; b < LANES; b++)
        begin
            if (lane_act[b])
            begin
                read_data = read_data
                          | (DATA_W'(lane_byte[b]) << {lane_off[b], 3'b000});
            end
        end
    end

endmodule

@@ hdl/brf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_div
// Constant divide of the trim drop by the lane count by reciprocal multiply,
// dividend registered on start, then quotient and remainder registered from it.
// ----------------------------------------------------------------------------
module brf_div
    import brf_pkg::*;
#(
    parameter int DW    = 11,
    parameter int LANES = LANES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DW-1:0]                 dividend,
    output logic                          done,
    output logic [DW-1:0]                 quotient,
    output logic [$clog2(2 * LANES)-1:0]  remainder
);

    localparam int TW = $clog2(2 * LANES);
    // scaled reciprocal, exact for every dividend below 2**DW
    localparam int SH = DW + 4;
    localparam int MW = SH + 1;
    localparam int PW = DW + MW;
    localparam int BKW = DW + 4;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) / 64'(LANES)) + 64'd1);

    logic            stage_reg;
    logic            done_reg;
    logic [DW-1:0]   dvd_reg;
    logic [DW-1:0]   quot_reg;
    logic [TW-1:0]   rem_reg;
    logic [PW-1:0]   prod;
    logic [DW-1:0]   quot_next;
    logic [BKW-1:0]  back;
    logic [TW-1:0]   rem_next;

    always_comb
    begin
        prod      = PW'(dvd_reg) * PW'(RECIP);
        quot_next = prod[SH +: DW];
        back      = BKW'(quot_next) * BKW'(LANES);
        rem_next  = TW'(BKW'(dvd_reg) - back);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
        end
        if (stage_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
